// ===== rtl/core/sdv_pkg.sv =====
package sdv_pkg;

	localparam int MAX_ROUND  = 64;
	localparam int TOKEN_BITS = 20;
	localparam int CNT_W      = $clog2(MAX_ROUND + 1);
	localparam int DIV_STEPS  = CNT_W + 16;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [15:0] EMA_KEEP      = 16'd58982;
	localparam logic [12:0] EMA_GAIN      = 13'd6554;
	localparam logic [15:0] EMA_HIGH      = 16'd39322;
	localparam logic [15:0] EMA_LOW       = 16'd19661;
	localparam logic [6:0]  SHORT_DRAFT   = 7'd3;
	localparam logic [6:0]  DEFAULT_DRAFT = 7'd6;
	localparam logic [16:0] RATE_EMPTY    = 17'd65535;
	localparam logic [23:0] POS_MAX       = 24'hFFFFFF;

	// register index, taken from paddr[2]
	localparam logic REG_MAX_DRAFT = 1'b0;
	localparam logic REG_EMA_START = 1'b1;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic pair_en;
		logic close_en;
		logic div_step;
		logic mul_en;
		logic add_en;
		logic fin_en;
	} sdv_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_busy;
	} sdv_stat_t;

	typedef struct packed {
		logic        ema_load;
		logic [15:0] ema_val;
		logic        max_load;
		logic [6:0]  max_val;
	} sdv_cfg_t;

	// Map the raw register to a usable draft length.
	function automatic logic [6:0] eff_max(input logic [6:0] m);
		logic [6:0] r;
		r = m;
		if (m == 7'd0)
			r = DEFAULT_DRAFT;
		else if (32'(m) > MAX_ROUND)
			r = 7'(MAX_ROUND);
		return r;
	endfunction

endpackage

// ===== rtl/core/speculative_draft_verifier_top.sv =====
// Speculative draft verifier. Feed one round as token-pair items (kind 0) in
// position order, then one close item (kind 1). A pair item is taken every
// cycle while no close is in progress; only the first 64 pairs of a round
// count, and matching stops at the first mismatch or missing target token. A
// close item yields one result item (accepted and drafted counts, rollback
// flag and position, updated Q0.16 acceptance average and next draft length).
// After the cycle that takes a close, no item is taken until it has passed
// the bit-serial rate divider, then one step for both multiplies, one for the
// sum and saturation, and one for the output load, which registers the result
// item. The output load waits while an earlier result item is still held,
// which stretches the close by the cycles of that stall. Pair items yield no
// result. Configuration sits on an APB port: max_draft_length at byte
// address 0, ema_start at 4. Writing either also reloads the live draft
// length or average; write only while the block is idle.
module speculative_draft_verifier_top import sdv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [19:0] draft_token,
	input  logic [19:0] target_token,
	input  logic        target_present,
	input  logic [23:0] base_position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  accepted_count,
	output logic        rollback_needed,
	output logic [23:0] rollback_position,
	output logic [6:0]  drafted_count,
	output logic [15:0] acceptance_ema,
	output logic [6:0]  next_draft_length
);

	logic [6:0]  max_draft_q;
	logic [15:0] ema_start_q;
	logic        wr_en;
	sdv_cfg_t    cfg;
	sdv_cmd_t    cmd;
	sdv_stat_t   stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes; the byte offset within a word is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_draft_q <= DEFAULT_DRAFT;
			ema_start_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MAX_DRAFT: max_draft_q <= pwdata[6:0];
				REG_EMA_START: ema_start_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_DRAFT: prdata = {25'd0, max_draft_q};
			REG_EMA_START: prdata = {16'd0, ema_start_q};
			default:       prdata = '0;
		endcase
	end

	// Reload the live state in the same cycle as the register write.
	assign cfg.ema_load = wr_en && paddr[2] == REG_EMA_START;
	assign cfg.ema_val  = pwdata[15:0];
	assign cfg.max_load = wr_en && paddr[2] == REG_MAX_DRAFT;
	assign cfg.max_val  = eff_max(pwdata[6:0]);

	sdv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	sdv_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg               (cfg),
		.max_len           (eff_max(max_draft_q)),
		.draft_token       (draft_token),
		.target_token      (target_token),
		.target_present    (target_present),
		.base_position     (base_position),
		.out_ready         (out_ready),
		.stat              (stat),
		.out_valid         (out_valid),
		.accepted_count    (accepted_count),
		.rollback_needed   (rollback_needed),
		.rollback_position (rollback_position),
		.drafted_count     (drafted_count),
		.acceptance_ema    (acceptance_ema),
		.next_draft_length (next_draft_length)
	);

endmodule

// ===== rtl/core/sdv_ctrl.sv =====
module sdv_ctrl import sdv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      kind,
	input  sdv_stat_t stat,
	output logic      in_ready,
	output sdv_cmd_t  cmd
);

	st_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_RUN: begin
				if (in_valid && kind)
					state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last)
					state_nx = ST_MUL;
			end
			ST_MUL: state_nx = ST_ADD;
			ST_ADD: state_nx = ST_FIN;
			ST_FIN: begin
				if (!stat.out_busy)
					state_nx = ST_RUN;
			end
			default: state_nx = ST_RUN;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_RUN: begin
				in_ready     = 1'b1;
				cmd.pair_en  = in_valid && !kind;
				cmd.close_en = in_valid && kind;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_MUL:  cmd.mul_en   = 1'b1;
			ST_ADD:  cmd.add_en   = 1'b1;
			ST_FIN:  cmd.fin_en   = !stat.out_busy;
			default: cmd          = '0;
		endcase
	end

endmodule

// ===== rtl/core/sdv_datapath.sv =====
module sdv_datapath import sdv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sdv_cmd_t    cmd,
	input  sdv_cfg_t    cfg,
	input  logic [6:0]  max_len,
	input  logic [19:0] draft_token,
	input  logic [19:0] target_token,
	input  logic        target_present,
	input  logic [23:0] base_position,
	input  logic        out_ready,
	output sdv_stat_t   stat,
	output logic        out_valid,
	output logic [6:0]  accepted_count,
	output logic        rollback_needed,
	output logic [23:0] rollback_position,
	output logic [6:0]  drafted_count,
	output logic [15:0] acceptance_ema,
	output logic [6:0]  next_draft_length
);

	logic             still_q;
	logic [CNT_W-1:0] match_q, pair_q;
	logic [CNT_W-1:0] acc_s1, dr_s1;
	logic [23:0]      base_s1;
	logic [CNT_W:0]   rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [31:0]      prod_a_q;
	logic [29:0]      prod_b_q;
	logic [15:0]      ema_q;
	logic [6:0]       draft_q;
	logic             out_valid_q;

	logic             tok_eq;
	logic [CNT_W:0]   trial;
	logic             ge;
	logic [16:0]      rate;
	logic [32:0]      sum;
	logic [16:0]      e_new;
	logic [24:0]      pos_sum;
	logic [23:0]      pos_sat;
	logic [6:0]       draft_nx;
	logic             need;

	assign tok_eq = draft_token[TOKEN_BITS-1:0] == target_token[TOKEN_BITS-1:0];
	assign trial  = {rem_q[CNT_W-1:0], quo_q[DIV_STEPS-1]};
	assign ge     = trial >= {1'b0, dr_s1};
	assign rate   = (dr_s1 == '0) ? RATE_EMPTY : quo_q[16:0];
	assign sum    = {1'b0, prod_a_q} + 33'(prod_b_q);
	assign e_new  = sum[32:16];
	assign need   = acc_s1 < dr_s1;
	assign pos_sum = 25'(base_s1) + 25'(acc_s1) + 25'd1;
	assign pos_sat = pos_sum[24] ? POS_MAX : pos_sum[23:0];

	always_comb begin
		draft_nx = draft_q;
		if (ema_q > EMA_HIGH && draft_q < max_len)
			draft_nx = max_len;
		else if (ema_q < EMA_LOW && draft_q > SHORT_DRAFT)
			draft_nx = SHORT_DRAFT;
	end

	assign stat.div_last = 32'(step_q) == DIV_STEPS - 1;
	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;

	// round counters and adaptive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q <= 1'b1;
			match_q <= '0;
			pair_q  <= '0;
			ema_q   <= '0;
			draft_q <= DEFAULT_DRAFT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pair_en && 32'(pair_q) < MAX_ROUND) begin
				pair_q <= pair_q + 1'b1;
				if (still_q && target_present && tok_eq)
					match_q <= match_q + 1'b1;
				else
					still_q <= 1'b0;
			end
			if (cmd.close_en) begin
				still_q <= 1'b1;
				match_q <= '0;
				pair_q  <= '0;
			end
			if (cfg.ema_load)
				ema_q <= cfg.ema_val;
			else if (cmd.add_en)
				ema_q <= e_new[16] ? 16'hFFFF : e_new[15:0];
			if (cfg.max_load)
				draft_q <= cfg.max_val;
			else if (cmd.fin_en)
				draft_q <= draft_nx;
			if (cmd.fin_en)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// close snapshot, divider, multiply stage and result registers
	always_ff @(posedge clk) begin
		if (cmd.close_en) begin
			acc_s1  <= match_q;
			dr_s1   <= pair_q;
			base_s1 <= base_position;
			rem_q   <= '0;
			quo_q   <= {match_q, 16'd0};
			step_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? trial - {1'b0, dr_s1} : trial;
			quo_q  <= {quo_q[DIV_STEPS-2:0], ge};
			step_q <= step_q + 1'b1;
		end
		if (cmd.mul_en) begin
			prod_a_q <= ema_q * EMA_KEEP;
			prod_b_q <= rate * EMA_GAIN;
		end
		if (cmd.fin_en) begin
			accepted_count    <= 7'(acc_s1);
			rollback_needed   <= need;
			rollback_position <= need ? pos_sat : 24'd0;
			drafted_count     <= 7'(dr_s1);
			acceptance_ema    <= ema_q;
			next_draft_length <= draft_nx;
		end
	end

endmodule

// ===== sim/sdv_round_checker.sv =====
module sdv_round_checker import sdv_pkg::*; #(
	parameter logic CLOSE_KIND = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic [19:0] draft_token,
	input  logic [19:0] target_token,
	input  logic        target_present,
	input  logic [23:0] base_position,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [6:0]  accepted_count,
	input  logic        rollback_needed,
	input  logic [23:0] rollback_position,
	input  logic [6:0]  drafted_count,
	input  logic [15:0] acceptance_ema,
	input  logic [6:0]  next_draft_length,
	output int          errors,
	output int          pending,
	output int          reports_seen
);

	localparam longint unsigned KEEP_WEIGHT = 58982;
	localparam longint unsigned GAIN_WEIGHT = 6554;
	localparam logic [15:0] HIGH_MARK    = 16'd39322;
	localparam logic [15:0] LOW_MARK     = 16'd19661;
	localparam logic [6:0]  SHORT_LEN    = 7'd3;
	localparam logic [6:0]  FALLBACK_LEN = 7'd6;
	localparam logic [31:0] RATE_EMPTY_ROUND = 32'd65535;
	localparam logic [24:0] POS_CEIL     = 25'hFFFFFF;

	typedef struct {
		logic [6:0]  accepted;
		logic        rollback;
		logic [23:0] rollback_at;
		logic [6:0]  drafted;
		logic [15:0] ema;
		logic [6:0]  next_len;
	} round_report_t;

	logic        prefix_alive;
	logic [6:0]  prefix_len;
	logic [6:0]  round_pairs;
	logic [15:0] ema_now;
	logic [6:0]  draft_len;
	logic [6:0]  limit_reg;

	round_report_t report_q[$];

	function automatic logic [6:0] usable_limit(input logic [6:0] m);
		if (m == 7'd0)
			return FALLBACK_LEN;
		if (m > 7'(MAX_ROUND))
			return 7'(MAX_ROUND);
		return m;
	endfunction

	// close the round: derive the report and move the average and draft length on
	function automatic round_report_t score_round(input logic [23:0] base);
		round_report_t r;
		logic [24:0]   pos;
		logic [31:0]   rate;
		logic [63:0]   mix;
		logic [6:0]    lim;
		r.accepted = prefix_len;
		r.drafted  = round_pairs;
		r.rollback = prefix_len < round_pairs;
		pos = 25'(base) + 25'(prefix_len) + 25'd1;
		if (!r.rollback)
			r.rollback_at = 24'd0;
		else if (pos > POS_CEIL)
			r.rollback_at = POS_CEIL[23:0];
		else
			r.rollback_at = pos[23:0];
		if (round_pairs == 7'd0)
			rate = RATE_EMPTY_ROUND;
		else
			rate = (32'(prefix_len) << 16) / 32'(round_pairs);
		mix = (64'(ema_now) * KEEP_WEIGHT + 64'(rate) * GAIN_WEIGHT) >> 16;
		ema_now = (mix > 64'd65535) ? 16'hFFFF : mix[15:0];
		lim = usable_limit(limit_reg);
		if (ema_now > HIGH_MARK && draft_len < lim)
			draft_len = lim;
		else if (ema_now < LOW_MARK && draft_len > SHORT_LEN)
			draft_len = SHORT_LEN;
		r.ema      = ema_now;
		r.next_len = draft_len;
		prefix_alive = 1'b1;
		prefix_len   = 7'd0;
		round_pairs  = 7'd0;
		return r;
	endfunction

	task automatic check_field(input string label, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		round_report_t want;
		if (!arst_n) begin
			prefix_alive = 1'b1;
			prefix_len   = 7'd0;
			round_pairs  = 7'd0;
			limit_reg    = FALLBACK_LEN;
			ema_now      = 16'd0;
			draft_len    = usable_limit(FALLBACK_LEN);
			report_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MAX_DRAFT) begin
					limit_reg = pwdata[6:0];
					draft_len = usable_limit(pwdata[6:0]);
				end else if (paddr[2] == REG_EMA_START) begin
					ema_now = pwdata[15:0];
				end
			end
			// retire the report first: it belongs to an earlier close
			if (out_valid && out_ready) begin
				reports_seen++;
				if (report_q.size() == 0) begin
					errors++;
					$display("%0t: report with no round closed, got acc %0d drafted %0d ema %0d",
						$time, accepted_count, drafted_count, acceptance_ema);
				end else begin
					want = report_q.pop_front();
					check_field("accepted_count", want.accepted, accepted_count);
					check_field("rollback_needed", want.rollback, rollback_needed);
					check_field("rollback_position", want.rollback_at, rollback_position);
					check_field("drafted_count", want.drafted, drafted_count);
					check_field("acceptance_ema", want.ema, acceptance_ema);
					check_field("next_draft_length", want.next_len, next_draft_length);
				end
			end
			if (in_valid && in_ready) begin
				if (kind == CLOSE_KIND) begin
					report_q.insert(report_q.size(), score_round(base_position));
				end else if (32'(round_pairs) < MAX_ROUND) begin
					round_pairs = round_pairs + 7'd1;
					if (prefix_alive && target_present &&
					    draft_token[TOKEN_BITS-1:0] == target_token[TOKEN_BITS-1:0])
						prefix_len = prefix_len + 7'd1;
					else
						prefix_alive = 1'b0;
				end
			end
		end
		pending = report_q.size();
	end

endmodule

// ===== sim/speculative_draft_verifier_top_test.sv =====
module speculative_draft_verifier_top_test;
	import sdv_pkg::*;

	// item kinds on the input channel
	localparam logic KIND_PAIR  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	localparam int TOTAL_ITEMS   = 1165;   // directed part plus about 1150 random items
	localparam int PHASE_ITEMS   = 110;    // items between register changes
	localparam int SETTLE_CYCLES = 32;     // idle margin once every report is back
	localparam int CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_ready;
	logic        kind;
	logic [19:0] draft_token, target_token;
	logic        target_present;
	logic [23:0] base_position;
	logic        out_valid, out_ready;
	logic [6:0]  accepted_count;
	logic        rollback_needed;
	logic [23:0] rollback_position;
	logic [6:0]  drafted_count;
	logic [15:0] acceptance_ema;
	logic [6:0]  next_draft_length;

	int errors, pending, reports_seen;
	int items_sent    = 0;
	int rounds_closed = 0;
	int settings_used = 0;
	int cycle_count   = 0;
	bit no_idle       = 1'b0;   // set for phases that run both channels flat out

	speculative_draft_verifier_top u_dut (.*);

	sdv_round_checker #(.CLOSE_KIND(KIND_CLOSE)) u_check (.*);

	always #2 clk = ~clk;

	// Gap ahead of an item, or the receiver's stall ahead of a report.
	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 5);
	endfunction

	// Present one item at a falling edge and hold it until taken. Leave valid
	// high on return so that a back-to-back item never drops it for a step.
	task automatic send_item(input logic k_in, input logic [19:0] d_in, input logic [19:0] t_in,
			input logic p_in, input logic [23:0] b_in);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= k_in;
		draft_token    <= d_in;
		target_token   <= t_in;
		target_present <= p_in;
		base_position  <= b_in;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// A pair carries a base position the block must ignore; randomise it.
	task automatic send_pair(input logic [19:0] d_in, input logic [19:0] t_in, input logic p_in);
		send_item(KIND_PAIR, d_in, t_in, p_in, 24'($urandom));
	endtask

	// A close carries token fields that mean nothing; randomise them too.
	task automatic send_close(input logic [23:0] b_in);
		send_item(KIND_CLOSE, 20'($urandom), 20'($urandom), 1'($urandom), b_in);
		rounds_closed++;
	endtask

	// Drop valid, wait for every report to come back, then let the close pipeline
	// drain before anything touches the registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup phase, access phase, then an idle gap so writes never abut.
	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// One round with random content. Most rounds are well formed: a matching
	// prefix, then a mismatch or a missing target, then random pairs. A few are
	// pure noise, some are empty, and some run past the round capacity.
	task automatic random_round(input int full_pct);
		int          shape, len, brk;
		logic [19:0] d;
		logic [23:0] b;
		shape = $urandom_range(0, 99);
		if (shape < 8)
			len = $urandom_range(60, 72);
		else if (shape < 13)
			len = 0;
		else
			len = $urandom_range(1, 12);
		brk = ($urandom_range(0, 99) < full_pct) ? len : $urandom_range(0, len);
		for (int i = 0; i < len; i++) begin
			d = 20'($urandom);
			if (shape >= 92)
				send_pair(d, 20'($urandom), 1'($urandom));
			else if (i < brk)
				send_pair(d, d, 1'b1);
			else if (i == brk) begin
				// end the prefix: a token mismatch, or no target at all
				if ($urandom_range(0, 1))
					send_pair(d, d ^ 20'($urandom_range(1, 20'hFFFFF)), 1'b1);
				else
					send_pair(d, $urandom_range(0, 1) ? d : 20'($urandom), 1'b0);
			end else
				send_pair(d, ($urandom_range(0, 3) == 0) ? d : 20'($urandom), 1'($urandom));
		end
		b = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 70))
			: 24'($urandom);
		send_close(b);
	endtask

	// Receiver: stall for a random gap ahead of each report, then take it.
	initial begin
		out_ready = 1'b0;
		forever begin
			int stall;
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** speculative_draft_verifier_top: FAILED **");
		$finish;
	end

	initial begin
		int          phase, phase_start, full_pct;
		logic [6:0]  lim;
		logic [15:0] ema;
		int          limit_pick[8];
		int          ema_pick[8];
		limit_pick = '{0, 1, 64, 127, 3, 65, 4, 6};
		ema_pick   = '{65535, 0, 39322, 39323, 19660, 19661, 52000, 10000};

		// hold every input at a known value from time zero
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = 3'd0;
		pwdata         = 32'd0;
		in_valid       = 1'b0;
		kind           = KIND_PAIR;
		draft_token    = 20'd0;
		target_token   = 20'd0;
		target_present = 1'b0;
		base_position  = 24'd0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, on the reset settings.
		// Close on an empty round, at the top of the position range.
		send_close(24'hFFFFFF);
		// Full match with extreme tokens: no rollback.
		send_pair(20'h00000, 20'h00000, 1'b1);
		send_pair(20'hFFFFF, 20'hFFFFF, 1'b1);
		send_close(24'h000000);
		// Mismatch after one match; rollback position saturates.
		send_pair(20'hAAAAA, 20'hAAAAA, 1'b1);
		send_pair(20'h00000, 20'hFFFFF, 1'b1);
		send_close(24'hFFFFFF);
		// Missing target with equal tokens ends matching; a later match is not counted.
		send_pair(20'h55555, 20'h55555, 1'b1);
		send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
		send_pair(20'h00001, 20'h00001, 1'b1);
		send_close(24'hFFFFFD);
		// Missing target on the very first pair.
		send_pair(20'h00000, 20'h00000, 1'b0);
		send_close(24'h000000);

		// Random part, phase by phase. Walk the register extremes first, then
		// random settings. Vary how often a round matches in full so the
		// average swings through both hysteresis marks.
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			settle();
			if (phase < 8) begin
				lim = 7'(limit_pick[phase]);
				ema = 16'(ema_pick[phase]);
			end else begin
				lim = 7'($urandom_range(0, 127));
				ema = 16'($urandom);
			end
			// upper data bits are noise the block must mask off
			write_reg(REG_MAX_DRAFT, {25'($urandom), lim});
			write_reg(REG_EMA_START, {16'($urandom), ema});
			settings_used++;
			no_idle = (phase % 4 == 3);
			case (phase % 3)
				0: full_pct = 90;
				1: full_pct = 10;
				default: full_pct = 50;
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS)
				random_round(full_pct);
			phase++;
		end

		// Drain: every report back, then let the pipeline fall quiet.
		settle();

		$display("Covered %0d items over %0d rounds and %0d register settings.",
			items_sent, rounds_closed, settings_used);
		$display("Compared %0d reports; %0d mismatches.", reports_seen, errors);
		if (errors == 0 && pending == 0)
			$display("** speculative_draft_verifier_top: PASSED **");
		else
			$display("** speculative_draft_verifier_top: FAILED **");
		$finish;
	end

endmodule
